### hdl/tgr_pkg.sv
// Shared types and constants for the text/graphics raster pixel generator.
package tgr_pkg;
  localparam int unsigned VideoBytesDef = 65536;
  localparam int unsigned ScreenRowsDef = 400;
  localparam int unsigned ScreenColsDef = 640;
  localparam int unsigned FontBytes     = 4096;
  localparam int unsigned FontAw        = 12;

  localparam logic [1:0] OpVideoWr = 2'd0;
  localparam logic [1:0] OpFontWr  = 2'd1;
  localparam logic [1:0] OpTick    = 2'd2;
  localparam logic [1:0] OpRender  = 2'd3;

  localparam logic [2:0] RegMode   = 3'd0;
  localparam logic [2:0] RegLines  = 3'd1;
  localparam logic [2:0] RegArea0  = 3'd2;
  localparam logic [2:0] RegArea1  = 3'd3;
  localparam logic [2:0] RegArea2  = 3'd4;
  localparam logic [2:0] RegArea3  = 3'd5;
  localparam logic [2:0] RegCursor = 3'd6;
  localparam logic [2:0] RegCurAdr = 3'd7;

  localparam logic [1:0] ModeGfxOnly = 2'd1;
  localparam logic [1:0] ModeTxtOnly = 2'd2;

  localparam logic [3:0] ColorOff  = 4'd0;
  localparam logic [3:0] ColorOn   = 4'd1;
  localparam logic [3:0] ColorHigh = 4'd9;

  // Controller to datapath commands.
  typedef struct packed {
    logic take;     // capture the input item
    logic find;     // evaluate one partition
    logic rd_code;  // issue video read of code (or gfx byte)
    logic rd_attr;  // issue attribute read
    logic rd_font;  // issue font read
    logic finish;   // compute and load result register
  } tgr_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic found;    // partition search finished with a hit
    logic miss;     // search finished with no hit / uncovered
    logic is_gfx;   // hit partition renders as graphics
  } tgr_sts_t;
endpackage

### hdl/tgr_ctrl.sv
// Sequencer for writes, ticks and pixel renders.
module tgr_ctrl import tgr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_op_i,
  output logic       in_ready_o,
  input  logic       out_busy_i,
  input  tgr_sts_t   sts_i,
  output tgr_cmd_t   cmd_o
);
  typedef enum logic [2:0] {
    StIdle, StFind, StAttr, StFont, StWait, StDone
  } state_e;
  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (in_op_i == OpRender) state_d = StFind;
        end
      end
      StFind: begin
        cmd_o.find = 1'b1;
        if (sts_i.miss) begin
          state_d = StDone;
        end else if (sts_i.found) begin
          cmd_o.rd_code = 1'b1;
          state_d = sts_i.is_gfx ? StWait : StAttr;
        end
      end
      StAttr: begin
        cmd_o.rd_attr = 1'b1;
        state_d = StFont;
      end
      StFont: begin
        cmd_o.rd_font = 1'b1;
        state_d = StWait;
      end
      StWait: state_d = StDone;
      StDone: begin
        if (!out_busy_i) begin
          cmd_o.finish = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  ap_render_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> state_q == StIdle) else $error("finish not back to idle");
  ap_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !cmd_o.take) else $error("take while busy");
  ap_font_after_attr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_font |-> $past(cmd_o.rd_attr)) else $error("font read order");
endmodule

### hdl/tgr_datapath.sv
// Memories, partition search, address generation and pixel shading.
module tgr_datapath import tgr_pkg::*; #(
  parameter int unsigned VIDEO_BYTES = VideoBytesDef,
  parameter int unsigned SCREEN_ROWS = ScreenRowsDef,
  parameter int unsigned SCREEN_COLS = ScreenColsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tgr_cmd_t    cmd_i,
  output tgr_sts_t    sts_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] mem_addr_i,
  input  logic [7:0]  write_byte_i,
  input  logic [9:0]  pixel_x_i,
  input  logic [8:0]  pixel_y_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [3:0]  pixel_color_o,
  output logic        row_covered_o
);
  localparam int unsigned Aw = $clog2(VIDEO_BYTES);

  logic [1:0]  mode_q;
  logic [9:0]  lines_q;
  logic [31:0] area_q [4];
  logic [23:0] cur_q;
  logic [17:0] cur_adr_q;
  logic [4:0]  blink_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 2'd0; lines_q <= 10'd400;
      area_q[0] <= '0; area_q[1] <= '0; area_q[2] <= '0; area_q[3] <= '0;
      cur_q <= '0; cur_adr_q <= '0; blink_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegMode:   mode_q    <= cfg_data_i[1:0];
          RegLines:  lines_q   <= cfg_data_i[9:0];
          RegArea0:  area_q[0] <= cfg_data_i;
          RegArea1:  area_q[1] <= cfg_data_i;
          RegArea2:  area_q[2] <= cfg_data_i;
          RegArea3:  area_q[3] <= cfg_data_i;
          RegCursor: cur_q     <= cfg_data_i[23:0];
          RegCurAdr: cur_adr_q <= cfg_data_i[17:0];
          default: ;
        endcase
      end
      if (cmd_i.take && op_i == OpTick) blink_q <= blink_q + 5'd1;
    end
  end

  // Captured pixel request.
  logic [9:0] x_q;
  logic [8:0] y_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      x_q <= pixel_x_i;
      y_q <= pixel_y_i;
    end
  end

  // Partition walk: one descriptor per cycle.
  logic [1:0]  pi_q;
  logic [10:0] used_q;
  logic [9:0]  plines;
  logic [11:0] pend;
  logic        hit, walk_end;
  assign plines   = area_q[pi_q][29:20];
  assign pend     = {1'b0, used_q} + {2'b0, plines};
  assign hit      = ({2'b0, y_q} >= used_q) && ({3'b0, y_q} < pend) &&
                    (used_q < {1'b0, lines_q});
  assign walk_end = !hit && ((used_q >= {1'b0, lines_q}) || (pi_q == 2'd3) ||
                    (pend[11]) || (pend[10:0] >= {1'b0, lines_q}));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pi_q <= '0; used_q <= '0;
    end else if (cmd_i.take) begin
      pi_q <= '0; used_q <= '0;
    end else if (cmd_i.find && !hit && !walk_end) begin
      pi_q <= pi_q + 2'd1; used_q <= pend[10:0];
    end
  end

  logic txt_only, gfx_only, cov_y, cov_x, gfx_c, wide_c;
  assign txt_only = (mode_q == ModeTxtOnly);
  assign gfx_only = (mode_q == ModeGfxOnly);
  assign cov_y    = hit && ({23'd0, y_q} < SCREEN_ROWS);
  assign cov_x    = {22'd0, x_q} < SCREEN_COLS;
  assign gfx_c    = gfx_only ? 1'b1 : txt_only ? 1'b0 : area_q[pi_q][30];
  assign wide_c   = area_q[pi_q][31];

  assign sts_o.found  = cov_y && cov_x;
  assign sts_o.miss   = (walk_end) || (hit && !(cov_y && cov_x));
  assign sts_o.is_gfx = gfx_c;

  // Address generation (from the partition found this cycle).
  logic [18:0] start;
  logic [8:0]  rel_y;
  logic [5:0]  cellrow;
  logic [9:0]  xcell;
  logic [31:0] gaddr, taddr;
  assign start   = {(txt_only ? {5'd0, area_q[pi_q][12:0]} : area_q[pi_q][17:0]), 1'b0};
  assign rel_y   = y_q - used_q[8:0];
  assign cellrow = {1'b0, y_q[8:4]} - {1'b0, used_q[8:4]};
  assign xcell   = wide_c ? (x_q >> 4) : (x_q >> 3);
  assign gaddr   = {13'd0, start} + 32'(rel_y) *
                   (wide_c ? 32'(SCREEN_COLS / 16) : 32'(SCREEN_COLS / 8)) +
                   {22'd0, xcell};
  assign taddr   = {13'd0, start} + 32'd2 * (32'(cellrow) *
                   (wide_c ? 32'(SCREEN_COLS / 16) : 32'(SCREEN_COLS / 8)) +
                   {22'd0, xcell});

  logic [Aw-1:0] cell_q;
  logic          curhit_q, gfx_q, cov_q;
  logic [2:0]    bit_q;
  logic [3:0]    fl_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.find) begin
      cell_q   <= gfx_c ? gaddr[Aw-1:0] : taddr[Aw-1:0];
      curhit_q <= (taddr[Aw-1:0] == {cur_adr_q, 1'b0});
      gfx_q    <= gfx_c;
      bit_q    <= wide_c ? x_q[3:1] : x_q[2:0];
      fl_q     <= y_q[3:0];
      cov_q    <= cov_y;
    end
  end

  // Memories.
  logic [7:0] vram [VIDEO_BYTES];
  logic [7:0] font [FontBytes];
  logic [7:0] vrd_q, code_q, frd_q;
  logic [Aw-1:0] vra;
  logic [Aw-1:0] vwa;
  assign vwa = Aw'(mem_addr_i);
  always_comb begin
    vra = cmd_i.rd_attr ? cell_q + Aw'(1) : (gfx_c ? gaddr[Aw-1:0] : taddr[Aw-1:0]);
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && op_i == OpVideoWr) vram[vwa] <= write_byte_i;
    if (cmd_i.rd_code || cmd_i.rd_attr) vrd_q <= vram[vra];
    if (cmd_i.rd_attr) code_q <= vrd_q;
    if (cmd_i.take && op_i == OpFontWr) font[mem_addr_i[FontAw-1:0]] <= write_byte_i;
    if (cmd_i.rd_font) frd_q <= font[{code_q, fl_q}];
  end

  // Shading; the attribute byte sits in vrd_q after the attribute read.
  logic       blink_on, cur_en, pix;
  logic [7:0] pat;
  logic [3:0] col;
  always_comb begin
    blink_on = blink_q[4];
    pat = frd_q;
    if (vrd_q[6] || (vrd_q[7] && blink_on)) pat = 8'd0;
    if (vrd_q[3]) pat = ~pat;
    pix = pat[bit_q];
    col = pix ? (vrd_q[2] ? ColorHigh : ColorOn) : ColorOff;
    cur_en = cur_q[7] && (cur_q[13] || !blink_on);
    if (cur_en && curhit_q && ({1'b0, fl_q} >= cur_q[12:8]) &&
        ({1'b0, fl_q} < cur_q[23:19])) col = ColorOn;
    if (gfx_q) col = vrd_q[bit_q] ? ColorOn : ColorOff;
  end

  // Flags of the final search step: gotpix_q marks a pixel found, misscov_q the row flag.
  logic gotpix_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gotpix_q <= 1'b0;
    else if (cmd_i.take) gotpix_q <= 1'b0;
    else if (cmd_i.find && (hit || walk_end)) gotpix_q <= sts_o.found;
  end
  logic misscov_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.find && (hit || walk_end)) misscov_q <= cov_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (cmd_i.finish) out_valid_o <= 1'b1;
    else if (out_ready_i) out_valid_o <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      pixel_color_o <= gotpix_q ? col : ColorOff;
      row_covered_o <= gotpix_q ? cov_q : misscov_q;
    end
  end

  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  ap_nocov_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !row_covered_o |-> pixel_color_o == ColorOff)
    else $error("uncovered pixel lit");
  ap_color_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pixel_color_o == ColorOff || pixel_color_o == ColorOn ||
    pixel_color_o == ColorHigh)) else $error("bad color");
endmodule

### hdl/text_graphics_raster_pixel_generator.sv
// Top level of the text/graphics raster pixel generator.
// Usage:
//  - s_axis carries one item per handshake: opcode selects a video byte write,
//    a font byte write, a frame tick (blink counter) or a pixel render.
//  - Writes and ticks complete when taken and produce no result item.
//  - A render walks up to four partition descriptors, one per cycle, then
//    reads the code, the attribute and the font byte (or only the graphics
//    byte) from synchronous memories in consecutive cycles.
//  - A render is paced by the partition walk and the dependent video then
//    font reads; a miss skips the reads and a graphics pixel skips the
//    attribute and font reads. One item is in work at a time; the next item
//    is taken in the cycle after the one that loads the result register.
//  - m_axis holds a result item in its output register until taken; the
//    block accepts the next item meanwhile unless a render must finish.
//  - cfg channel writes a register by index; always ready.
//  - Reset clears registers to defaults and the blink counter; video and
//    font memories are not cleared and must be written before being read.
module text_graphics_raster_pixel_generator import tgr_pkg::*; #(
  parameter int unsigned VIDEO_BYTES = VideoBytesDef,
  parameter int unsigned SCREEN_ROWS = ScreenRowsDef,
  parameter int unsigned SCREEN_COLS = ScreenColsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: mem_addr[15:0], write_byte[23:16], pixel_x[33:24], pixel_y[42:34]
  input  logic [47:0] s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: pixel_color[3:0]
  output logic [7:0]  m_axis_tdata,
  // tuser: row_covered[0]
  output logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  tgr_cmd_t cmd;
  tgr_sts_t sts;
  logic [3:0] color;

  assign cfg_ready_o = 1'b1;
  assign m_axis_tdata = {4'd0, color};

  tgr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .out_busy_i (m_axis_tvalid && !m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tgr_datapath #(
    .VIDEO_BYTES(VIDEO_BYTES), .SCREEN_ROWS(SCREEN_ROWS), .SCREEN_COLS(SCREEN_COLS)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (s_axis_tuser),
    .mem_addr_i   (s_axis_tdata[15:0]),
    .write_byte_i (s_axis_tdata[23:16]),
    .pixel_x_i    (s_axis_tdata[33:24]),
    .pixel_y_i    (s_axis_tdata[42:34]),
    .cfg_we_i     (cfg_valid_i),
    .cfg_idx_i    (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .pixel_color_o(color),
    .row_covered_o(m_axis_tuser)
  );
endmodule
